// ===== sv/vfh_pkg.sv =====
// Shared types and constants for the compressed-image frame header parser.
// No dependencies; all design modules import this package.
`default_nettype none

package vfh_pkg;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_TOO_SHORT     = 4'd1,
    ST_RIFF_TRUNC    = 4'd2,
    ST_NO_WEBP       = 4'd3,
    ST_BAD_FOURCC    = 4'd4,
    ST_SIZE_MISMATCH = 4'd5,
    ST_PIC_SHORT     = 4'd6,
    ST_BAD_START     = 4'd7,
    ST_BAD_PART_LEN  = 4'd8
  } vfh_status_e;

  localparam logic [31:0] SIG_RIFF     = 32'h4646_4952;
  localparam logic [31:0] SIG_WEBP     = 32'h5042_4557;
  localparam logic [31:0] SIG_VP8      = 32'h2038_5056;
  localparam logic [31:0] MIN_LEN      = 32'd4;
  localparam logic [31:0] RIFF_MIN_LEN = 32'd24;
  localparam logic [31:0] RIFF_SUM_ADD = 32'd8;
  localparam logic [31:0] PIC_HDR_LEN  = 32'd7;
  localparam logic [4:0]  RIFF_HDR_LEN = 5'd20;
  localparam logic [4:0]  TAG_LEN      = 5'd3;
  localparam logic [4:0]  FRAME_HDR_LEN = 5'd10;
  localparam logic [4:0]  IDX_MAX      = 5'd31;
  localparam logic [7:0]  START_CODE0  = 8'h9d;
  localparam logic [7:0]  START_CODE1  = 8'h01;
  localparam logic [7:0]  START_CODE2  = 8'h2a;
  localparam logic [14:0] MB_ROUND     = 15'd15;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [31:0] buffer_length;
  } vfh_byte_t;

  typedef struct packed {
    vfh_status_e status;
    logic        key_frame;
    logic [2:0]  profile;
    logic        show_frame;
    logic [18:0] first_part_length;
    logic [13:0] pic_width;
    logic [1:0]  width_scale;
    logic [13:0] pic_height;
    logic [1:0]  height_scale;
    logic [10:0] mb_cols;
    logic [10:0] mb_rows;
    logic [4:0]  payload_offset;
  } vfh_result_t;

endpackage

`default_nettype wire

// ===== sv/vfh_byte_if.sv =====
// Input channel: one buffer byte per item with valid/ready handshake.
// Stand-alone interface, no package dependency.
`default_nettype none

interface vfh_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [31:0] buffer_length;

  modport source (output valid, output data_byte, output first_byte,
                  output buffer_length, input ready);
  modport sink   (input valid, input data_byte, input first_byte,
                  input buffer_length, output ready);
endinterface

`default_nettype wire

// ===== sv/vfh_result_if.sv =====
// Result channel: one parse result per item with valid/ready handshake.
// Stand-alone interface, no package dependency.
`default_nettype none

interface vfh_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        key_frame;
  logic [2:0]  profile;
  logic        show_frame;
  logic [18:0] first_part_length;
  logic [13:0] pic_width;
  logic [1:0]  width_scale;
  logic [13:0] pic_height;
  logic [1:0]  height_scale;
  logic [10:0] mb_cols;
  logic [10:0] mb_rows;
  logic [4:0]  payload_offset;

  modport source (output valid, output status, output key_frame, output profile,
                  output show_frame, output first_part_length, output pic_width,
                  output width_scale, output pic_height, output height_scale,
                  output mb_cols, output mb_rows, output payload_offset,
                  input ready);
  modport sink   (input valid, input status, input key_frame, input profile,
                  input show_frame, input first_part_length, input pic_width,
                  input width_scale, input pic_height, input height_scale,
                  input mb_cols, input mb_rows, input payload_offset,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/vfh_in_stage.sv =====
// Input register stage: captures one byte item and holds it until the parser takes it.
// Depends on vfh_pkg.
`default_nettype none

module vfh_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vfh_pkg::vfh_byte_t in_item_i,
  output logic              item_valid_o,
  output vfh_pkg::vfh_byte_t item_o,
  input  logic              take_i
);
  import vfh_pkg::*;

  logic      valid_q;
  vfh_byte_t item_q;

  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vfh_parse.sv =====
// Parse state, per-byte decode and result register.
// Depends on vfh_pkg.
`default_nettype none

module vfh_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  vfh_pkg::vfh_byte_t  item_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vfh_pkg::vfh_result_t result_o
);
  import vfh_pkg::*;

  logic [4:0]  idx_q, idx_d, idx_c;
  logic [31:0] rem_q, rem_d, rem_c;
  logic        riff_q, riff_d, riff_c;
  logic [31:0] win_q, win_d, win_c;
  logic [31:0] rlen_q, rlen_d, rlen_c;
  logic [31:0] clen_q, clen_d, clen_c;
  logic [23:0] tag_q, tag_d, tag_c;
  logic [31:0] pic_q, pic_d, pic_c;
  logic        done_q, done_d, done_c;

  logic        out_valid_q;
  vfh_result_t result_q;

  logic        emit;
  vfh_status_e status;
  logic        have_tag, have_pic;
  logic [4:0]  offset;
  logic [7:0]  b;
  logic [4:0]  lane_sel;
  logic        fp_en;
  logic [4:0]  fp;
  logic        tag_done, chk_en, pic_done;
  logic [7:0]  chk_val;
  logic [31:0] full_word;
  logic [4:0]  base, off3, off10;
  logic [31:0] d3, d10;
  logic        key_new, key_cur;
  logic [18:0] fpl_new;
  logic [14:0] w_sum, h_sum;
  vfh_result_t res;

  assign take_o      = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  always_comb begin
    b        = item_i.data_byte;
    if (item_i.first_byte) begin
      idx_c  = '0;
      rem_c  = item_i.buffer_length;
      riff_c = 1'b0;
      win_c  = '0;
      rlen_c = '0;
      clen_c = '0;
      tag_c  = '0;
      pic_c  = '0;
      done_c = 1'b0;
    end else begin
      idx_c  = idx_q;
      rem_c  = rem_q;
      riff_c = riff_q;
      win_c  = win_q;
      rlen_c = rlen_q;
      clen_c = clen_q;
      tag_c  = tag_q;
      pic_c  = pic_q;
      done_c = done_q;
    end
    lane_sel = {idx_c[1:0], 3'b000};

    idx_d  = idx_c;
    rem_d  = rem_c;
    riff_d = riff_c;
    win_d  = win_c;
    rlen_d = rlen_c;
    clen_d = clen_c;
    tag_d  = tag_c;
    pic_d  = pic_c;
    done_d = done_c;

    emit     = 1'b0;
    status   = ST_OK;
    have_tag = 1'b0;
    have_pic = 1'b0;
    offset   = '0;
    fp_en    = 1'b0;
    fp       = '0;
    tag_done = 1'b0;
    chk_en   = 1'b0;
    chk_val  = START_CODE0;
    pic_done = 1'b0;
    full_word = {b, win_c[23:0]};

    base    = riff_c ? RIFF_HDR_LEN : 5'd0;
    off3    = base + TAG_LEN;
    off10   = base + FRAME_HDR_LEN;
    d3      = rem_c - {27'd0, off3};
    d10     = rem_c - {27'd0, off10};
    key_cur = !tag_c[0];

    // header byte capture, or frame-relative byte position
    if (!done_c && !(item_i.first_byte && item_i.buffer_length <= MIN_LEN)) begin
      if (idx_c < 5'd4) begin
        win_d[lane_sel +: 8] = b;
        if (idx_c == 5'd3) begin
          if (full_word != SIG_RIFF) begin
            tag_d    = full_word[23:0];
            tag_done = 1'b1;
            chk_en   = 1'b1;
            chk_val  = START_CODE0;
          end
        end
      end else if (!riff_c) begin
        fp_en = 1'b1;
        fp    = idx_c;
      end else if (idx_c < RIFF_HDR_LEN) begin
        if (idx_c < 5'd8) begin
          rlen_d[lane_sel +: 8] = b;
        end else if (idx_c < 5'd16) begin
          win_d[lane_sel +: 8] = b;
        end else begin
          clen_d[lane_sel +: 8] = b;
        end
      end else begin
        fp_en = 1'b1;
        fp    = idx_c - RIFF_HDR_LEN;
      end
    end

    if (fp_en) begin
      case (fp)
        5'd0:    tag_d[7:0]   = b;
        5'd1:    tag_d[15:8]  = b;
        5'd2: begin
          tag_d[23:16] = b;
          tag_done     = 1'b1;
        end
        5'd3: begin
          chk_en  = 1'b1;
          chk_val = START_CODE0;
        end
        5'd4: begin
          chk_en  = 1'b1;
          chk_val = START_CODE1;
        end
        5'd5: begin
          chk_en  = 1'b1;
          chk_val = START_CODE2;
        end
        5'd6:    pic_d[7:0]   = b;
        5'd7:    pic_d[15:8]  = b;
        5'd8:    pic_d[23:16] = b;
        5'd9: begin
          pic_d[31:24] = b;
          pic_done     = 1'b1;
        end
        default: ;
      endcase
    end

    key_new = !tag_d[0];
    fpl_new = tag_d[23:5];

    if (item_i.first_byte && item_i.buffer_length <= MIN_LEN) begin
      emit   = 1'b1;
      status = ST_TOO_SHORT;
    end else if (!done_c) begin
      if (idx_c == 5'd3 && full_word == SIG_RIFF) begin
        if (rem_c < RIFF_MIN_LEN) begin
          emit   = 1'b1;
          status = ST_RIFF_TRUNC;
        end else begin
          riff_d = 1'b1;
        end
      end else if (riff_c && idx_c == 5'd11 && full_word != SIG_WEBP) begin
        emit   = 1'b1;
        status = ST_NO_WEBP;
      end else if (riff_c && idx_c == 5'd15 && full_word != SIG_VP8) begin
        emit   = 1'b1;
        status = ST_BAD_FOURCC;
      end else if (riff_c && idx_c == 5'd19 &&
                   (({b, clen_c[23:0]} > (rlen_c + RIFF_SUM_ADD)) || clen_c[0])) begin
        emit   = 1'b1;
        status = ST_SIZE_MISMATCH;
      end else if (tag_done) begin
        have_tag = 1'b1;
        if (key_new) begin
          if (d3 < PIC_HDR_LEN) begin
            emit   = 1'b1;
            status = ST_PIC_SHORT;
          end else if (chk_en && b != chk_val) begin
            emit   = 1'b1;
            status = ST_BAD_START;
          end
        end else begin
          emit   = 1'b1;
          offset = off3;
          status = ({13'd0, fpl_new} > d3) ? ST_BAD_PART_LEN : ST_OK;
        end
      end else if (key_cur && chk_en && b != chk_val) begin
        emit     = 1'b1;
        have_tag = 1'b1;
        status   = ST_BAD_START;
      end else if (key_cur && pic_done) begin
        emit     = 1'b1;
        have_tag = 1'b1;
        have_pic = 1'b1;
        offset   = off10;
        status   = ({13'd0, fpl_new} > d10) ? ST_BAD_PART_LEN : ST_OK;
      end
      if (!emit && idx_c != IDX_MAX) begin
        idx_d = idx_c + 5'd1;
      end
    end
    if (emit) begin
      done_d = 1'b1;
    end

    w_sum = {1'b0, pic_d[13:0]} + MB_ROUND;
    h_sum = {1'b0, pic_d[29:16]} + MB_ROUND;

    res                = '0;
    res.status         = status;
    res.payload_offset = offset;
    if (have_tag) begin
      res.key_frame         = key_new;
      res.profile           = tag_d[3:1];
      res.show_frame        = tag_d[4];
      res.first_part_length = fpl_new;
    end
    if (have_pic) begin
      res.pic_width    = pic_d[13:0];
      res.width_scale  = pic_d[15:14];
      res.pic_height   = pic_d[29:16];
      res.height_scale = pic_d[31:30];
      res.mb_cols      = w_sum[14:4];
      res.mb_rows      = h_sum[14:4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rem_q       <= '0;
      riff_q      <= 1'b0;
      win_q       <= '0;
      rlen_q      <= '0;
      clen_q      <= '0;
      tag_q       <= '0;
      pic_q       <= '0;
      done_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        idx_q  <= idx_d;
        rem_q  <= rem_d;
        riff_q <= riff_d;
        win_q  <= win_d;
        rlen_q <= rlen_d;
        clen_q <= clen_d;
        tag_q  <= tag_d;
        pic_q  <= pic_d;
        done_q <= done_d;
      end
      if (take_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      result_q <= res;
    end
  end

  a_done_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && emit |=> done_q)
    else $error("parse not closed after result");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != IDX_MAX)
    else $error("byte index ran past the frame header");

  a_key_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.status == ST_OK && result_q.key_frame |->
      (result_q.payload_offset == 5'd10 || result_q.payload_offset == 5'd30))
    else $error("key frame result with wrong payload offset");

  a_short_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.status == ST_TOO_SHORT |->
      (result_q.key_frame == 1'b0 && result_q.payload_offset == 5'd0))
    else $error("too-short result carries frame fields");

endmodule

`default_nettype wire

// ===== sv/webp_vp8_frame_header_parser.sv =====
// Channel   Dir  Payload                                          Handshake
// byte_i    in   data_byte, first_byte, buffer_length             valid/ready
// result_o  out  status, tag fields, picture fields, payload_offset valid/ready
//
// One byte item per cycle sustained while the result register does not stall;
// a byte is decoded from the input register, and its result (if any) loads the
// result register. Between the byte accept and result valid lie the input
// register and the result register.
// Reset is asynchronous, active low; after reset bytes are dropped until first_byte.
// A stalled result register holds the input stage; the input register keeps
// taking bytes while a result is taken in the same cycle.
// Depends on vfh_pkg, vfh_byte_if, vfh_result_if, vfh_in_stage, vfh_parse.
`default_nettype none

module webp_vp8_frame_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  vfh_byte_if.sink    byte_i,
  vfh_result_if.source result_o
);
  import vfh_pkg::*;

  vfh_byte_t   in_item;
  vfh_byte_t   item;
  logic        item_valid;
  logic        take;
  logic        out_valid;
  vfh_result_t result;

  assign in_item.data_byte     = byte_i.data_byte;
  assign in_item.first_byte    = byte_i.first_byte;
  assign in_item.buffer_length = byte_i.buffer_length;

  vfh_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (byte_i.valid),
    .in_ready_o   (byte_i.ready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  vfh_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (out_valid),
    .out_ready_i  (result_o.ready),
    .result_o     (result)
  );

  assign result_o.valid             = out_valid;
  assign result_o.status            = result.status;
  assign result_o.key_frame         = result.key_frame;
  assign result_o.profile           = result.profile;
  assign result_o.show_frame        = result.show_frame;
  assign result_o.first_part_length = result.first_part_length;
  assign result_o.pic_width         = result.pic_width;
  assign result_o.width_scale       = result.width_scale;
  assign result_o.pic_height        = result.pic_height;
  assign result_o.height_scale      = result.height_scale;
  assign result_o.mb_cols           = result.mb_cols;
  assign result_o.mb_rows           = result.mb_rows;
  assign result_o.payload_offset    = result.payload_offset;

endmodule

`default_nettype wire
